// ===== src/command_frame_receiver_crc8_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Command frame receiver: assertion macros
// Shared property shorthands for the checker, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_RECEIVER_CRC8_UNIT_MACROS_SVH
`define COMMAND_FRAME_RECEIVER_CRC8_UNIT_MACROS_SVH

// Same-cycle implication.
`define CFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfr_pkg
// Frame constants, command and result codes, and the CRC-8 step.
// ----------------------------------------------------------------------------
package cfr_pkg;

    localparam logic [7:0] HDR_BYTE = 8'hAA;
    localparam logic [7:0] TAIL_ONE = 8'hFF;
    localparam logic [7:0] TAIL_TWO = 8'hEE;
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam int         STORE_LEN = 9;

    // Command byte codes
    localparam logic [7:0] CMD_ARM    = 8'h02;
    localparam logic [7:0] CMD_GIMBAL = 8'h03;
    localparam logic [7:0] CMD_VALVE  = 8'h04;
    localparam logic [7:0] CMD_ANSWER = 8'h05;
    localparam logic [7:0] CMD_PUMP   = 8'h06;

    // Result kind codes
    localparam logic [1:0] KIND_ARM    = 2'd0;
    localparam logic [1:0] KIND_GIMBAL = 2'd1;
    localparam logic [1:0] KIND_VALVE  = 2'd2;
    localparam logic [1:0] KIND_PUMP   = 2'd3;

    typedef struct packed {
        logic        hit;
        logic [1:0]  command_kind;
        logic [1:0]  target_index;
        logic [31:0] first_word;
        logic [31:0] second_word;
        logic        switch_state;
    } cfr_result_t;

    // One byte through the MSB-first CRC-8 shift register.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Payload length of a command; zero marks an unknown command.
    function automatic logic [3:0] cmd_len(input logic [7:0] cmd);
        logic [3:0] len;
        case (cmd)
            CMD_ARM:    len = 4'd9;
            CMD_GIMBAL: len = 4'd9;
            CMD_VALVE:  len = 4'd2;
            CMD_PUMP:   len = 4'd5;
            CMD_ANSWER: len = 4'd3;
            default:    len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== src/cfr_parser.sv =====
// ----------------------------------------------------------------------------
// cfr_parser
// Frame state machine, payload store, running CRC and command decode.
// ----------------------------------------------------------------------------
module cfr_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    output cfr_pkg::cfr_result_t result
);
    import cfr_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_CMD    = 3'd1,
        PH_DATA   = 3'd2,
        PH_TAIL1  = 3'd3,
        PH_TAIL2  = 3'd4,
        PH_CRC    = 3'd5
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [3:0] wpos_reg, wpos_next;
    logic [3:0] left_reg, left_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] store_reg [STORE_LEN];
    logic       store_we;
    logic [3:0] len;
    logic [7:0] want;
    logic [7:0] p0;

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        wpos_next  = wpos_reg;
        left_next  = left_reg;
        crc_next   = crc_reg;
        store_we   = 1'b0;
        len        = cmd_len(rx_byte);
        want       = (phase_reg == PH_TAIL1) ? TAIL_ONE : TAIL_TWO;
        if (step)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (rx_byte == HDR_BYTE)
                    begin
                        phase_next = PH_CMD;
                        wpos_next  = 4'd0;
                        crc_next   = crc8_step(8'h00, HDR_BYTE);
                    end
                end
                PH_CMD:
                begin
                    if (len == 4'd0)
                    begin
                        phase_next = PH_HEADER;
                        wpos_next  = 4'd0;
                    end
                    else
                    begin
                        cmd_next   = rx_byte;
                        left_next  = len;
                        crc_next   = crc8_step(crc_reg, rx_byte);
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (wpos_reg < 4'(STORE_LEN) && left_reg != 4'd0)
                    begin
                        store_we  = 1'b1;
                        wpos_next = wpos_reg + 4'd1;
                        crc_next  = crc8_step(crc_reg, rx_byte);
                    end
                    if (left_reg <= 4'd1)
                    begin
                        left_next  = 4'd0;
                        phase_next = PH_TAIL1;
                    end
                    else
                    begin
                        left_next = left_reg - 4'd1;
                    end
                end
                PH_TAIL1, PH_TAIL2:
                begin
                    if (rx_byte == want)
                    begin
                        crc_next   = crc8_step(crc_reg, rx_byte);
                        phase_next = (phase_reg == PH_TAIL1) ? PH_TAIL2 : PH_CRC;
                    end
                    else if (rx_byte == HDR_BYTE)
                    begin
                        phase_next = PH_CMD;
                        wpos_next  = 4'd0;
                        crc_next   = crc8_step(8'h00, HDR_BYTE);
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                        wpos_next  = 4'd0;
                    end
                end
                default:
                begin
                    // CRC byte and unused codes both end in the hunt
                    phase_next = PH_HEADER;
                    wpos_next  = 4'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            cmd_reg   <= 8'h00;
            wpos_reg  <= 4'd0;
            left_reg  <= 4'd0;
            crc_reg   <= 8'h00;
        end
        else
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            wpos_reg  <= wpos_next;
            left_reg  <= left_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[wpos_reg] <= rx_byte;
        end
    end

    // Decode on the CRC byte
    assign p0 = store_reg[0];

    always_comb
    begin
        result = '0;
        if (step && phase_reg == PH_CRC && rx_byte == crc_reg)
        begin
            case (cmd_reg)
                CMD_ARM:
                begin
                    result.hit          = (p0 <= 8'd3);
                    result.command_kind = KIND_ARM;
                    result.target_index = p0[1:0];
                    result.first_word   = {store_reg[4], store_reg[3], store_reg[2], store_reg[1]};
                    result.second_word  = {store_reg[8], store_reg[7], store_reg[6], store_reg[5]};
                end
                CMD_GIMBAL:
                begin
                    result.hit          = 1'b1;
                    result.command_kind = KIND_GIMBAL;
                    result.first_word   = {store_reg[4], store_reg[3], store_reg[2], store_reg[1]};
                    result.second_word  = {store_reg[8], store_reg[7], store_reg[6], store_reg[5]};
                end
                CMD_VALVE:
                begin
                    result.hit          = (p0 < 8'd4);
                    result.command_kind = KIND_VALVE;
                    result.target_index = p0[1:0];
                    result.switch_state = store_reg[1][0];
                end
                CMD_PUMP:
                begin
                    result.hit          = 1'b1;
                    result.command_kind = KIND_PUMP;
                    if (p0 != 8'd0)
                    begin
                        result.first_word   = {store_reg[4], store_reg[3], store_reg[2], store_reg[1]};
                        result.switch_state = 1'b1;
                    end
                end
                default:
                begin
                    result = '0;
                end
            endcase
        end
    end

endmodule

// ===== src/command_frame_receiver_crc8_unit.sv =====
// ----------------------------------------------------------------------------
// command_frame_receiver_crc8_unit
// Byte-serial command frame receiver with CRC-8 check and command decode.
// ----------------------------------------------------------------------------
//
//   channel  handshake             payload
//   -------  --------------------  ---------------------------------------
//   rx       rx_valid / rx_ready   rx_byte
//   cmd      cmd_valid / cmd_ready command_kind, target_index, first_word,
//                                  second_word, switch_state
//
// One byte per cycle sustained while commands are taken. A request lands
// in the input register at its accepting edge; once the output slot is
// free the parser steps its state, CRC and decode and loads any command
// into the output register, from which it is offered.
// Reset clears the input and output valid bits and the parser state; the
// payload store needs no clearing since each frame writes what it decodes.
// A stalled command holds in the output register; the parser stops only
// when it has a byte and the output register is full and not taken.
// ----------------------------------------------------------------------------
module command_frame_receiver_crc8_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output logic [1:0]  command_kind,
    output logic [1:0]  target_index,
    output logic [31:0] first_word,
    output logic [31:0] second_word,
    output logic        switch_state
);
    import cfr_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        advance;
    logic        out_valid_reg, out_valid_next;
    cfr_result_t out_reg;
    cfr_result_t result;

    // Step the parser whenever a byte is held and the output slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || cmd_ready);
    assign rx_ready = !in_valid_reg || advance;

    cfr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (rx_ready)
        begin
            in_valid_next = rx_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = result.hit;
        end
        else if (cmd_ready)
        begin
            // drop the command once taken
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: hold the byte and the command, no reset
    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance && result.hit)
        begin
            out_reg <= result;
        end
    end

    assign cmd_valid    = out_valid_reg;
    assign command_kind = out_reg.command_kind;
    assign target_index = out_reg.target_index;
    assign first_word   = out_reg.first_word;
    assign second_word  = out_reg.second_word;
    assign switch_state = out_reg.switch_state;

endmodule

// ===== src/cfr_checker.sv =====
// ----------------------------------------------------------------------------
// cfr_checker
// Port-level checks for the command frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "command_frame_receiver_crc8_unit_macros.svh"

module cfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rx_valid,
    input logic        rx_ready,
    input logic [7:0]  rx_byte,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic [1:0]  command_kind,
    input logic [1:0]  target_index,
    input logic [31:0] first_word,
    input logic [31:0] second_word,
    input logic        switch_state
);
    import cfr_pkg::*;

    `CFR_ASSERT_NEXT(a_cmd_hold, cmd_valid && !cmd_ready, cmd_valid && $stable(command_kind) && $stable(target_index) && $stable(first_word) && $stable(second_word) && $stable(switch_state), "stalled command changed")
    `CFR_ASSERT_NOW(a_rx_open, !cmd_valid, rx_ready, "byte request refused with empty output")
    `CFR_ASSERT_NOW(a_valve_words, cmd_valid && command_kind == KIND_VALVE, first_word == 32'd0 && second_word == 32'd0, "valve command carries words")
    `CFR_ASSERT_NOW(a_pump_off, cmd_valid && command_kind == KIND_PUMP && !switch_state, first_word == 32'd0 && second_word == 32'd0 && target_index == 2'd0, "pump off with nonzero fields")

endmodule

bind command_frame_receiver_crc8_unit cfr_checker u_cfr_checker (.*);
